// ===== rtl/sshs_pkg.sv =====
// ----------------------------------------------------------------------------
// sshs_pkg
// Shared widths, fixed-point constants and the quarter-wave sine table for
// the sine-smoothed Heaviside datapath.
// ----------------------------------------------------------------------------
package sshs_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int X_W         = 32;
    localparam int INV_W       = 32;
    localparam int SLOPE_W     = 32;
    localparam int UMAG_W      = FRAC_BITS + 1;
    localparam int PROD_W      = X_W + INV_W;
    localparam int SINE_IDX_W  = 8;
    localparam int SINE_DEPTH  = 1 << SINE_IDX_W;
    localparam int Q30         = 30;
    localparam int SINE_W      = Q30 + 1;
    localparam int HVAL_W      = Q30 + 1;
    localparam int INV_PI_W    = 29;
    localparam int SPI_W       = 29;
    localparam int TOT_W       = Q30 + 3;

    localparam logic [UMAG_W-1:0] ONE_Q     = UMAG_W'(1) << FRAC_BITS;
    localparam logic [31:0]       ONE_Q30   = 32'(1) << Q30;
    localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;
    localparam logic [INV_PI_W-1:0] INV_PI_Q30 = INV_PI_W'(341782638);

    typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_DEPTH];

    // unsigned shift-subtract quotient, table build only
    function automatic logic [63:0] div_u64(input logic [63:0] num,
                                            input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sin(pi/2 * i / depth) in Q1.30, truncating Taylor series
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] th;
        logic [63:0] term;
        longint      sum;
        for (int i = 0; i <= SINE_DEPTH; i++)
        begin
            th   = (64'(i) * HALF_PI_Q30 + (64'(1) << (SINE_IDX_W - 1))) >> SINE_IDX_W;
            term = th;
            sum  = longint'(th);
            for (int k = 1; k <= 12; k++)
            begin
                term = (term * th) >> Q30;
                term = (term * th) >> Q30;
                term = div_u64(term, 64'(2 * k) * 64'(2 * k + 1));
                if ((k & 1) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > longint'(ONE_Q30))
                sum = longint'(ONE_Q30);
            rom[i] = SINE_W'(sum);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== rtl/sine_smoothed_heaviside.sv =====
// ----------------------------------------------------------------------------
// sine_smoothed_heaviside
// Smoothed Heaviside step H(x) = 0.5*(1+u+sin(pi*u)/pi), u = clamp(x/d),
// with its slope 0.5*(1+cos(pi*u))/d, over an eight-stage pipeline.
//
//  channel   handshake                signals
//  -------   ----------------------   ------------------------------
//  in        in_valid / in_ready      level_value
//  out       out_valid / out_ready    step_value, step_slope
//  cfg       cfg_wr_en (no wait)      cfg_wr_data -> inv_band_width
//
// One request per cycle while the pipe is not stalled; each result is held
// in the output register until it is taken.
// The whole pipe advances together whenever the output register is empty or
// being taken, so a stall freezes every stage in place.
// Reset clears the stage valid bits and loads inv_band_width with 1.0.
// ----------------------------------------------------------------------------
module sine_smoothed_heaviside (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [sshs_pkg::X_W-1:0]     level_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic        [sshs_pkg::UMAG_W-1:0]  step_value,
    output logic        [sshs_pkg::SLOPE_W-1:0] step_slope,
    input  logic                                cfg_wr_en,
    input  logic        [sshs_pkg::INV_W-1:0]   cfg_wr_data
);
    import sshs_pkg::*;

    localparam int NSTAGE = 8;

    logic                 adv;
    logic [NSTAGE-1:0]    valid_reg;
    logic [INV_W-1:0]     inv_band_width_reg;

    logic [UMAG_W-1:0]    umag_c;
    logic                 neg_c;
    logic [INV_W-1:0]     inv_c;
    logic [UMAG_W:0]      q;
    logic                 cneg_c;
    logic [UMAG_W-1:0]    ts;
    logic [UMAG_W-1:0]    tc;
    logic [SINE_W-1:0]    smag_e;
    logic [SINE_W-1:0]    cmag_e;

    logic [UMAG_W-1:0]    umag_d_reg;
    logic                 neg_d_reg;
    logic                 cneg_d_reg;
    logic [INV_W-1:0]     inv_d_reg;
    logic [UMAG_W-1:0]    umag_e_reg;
    logic                 neg_e_reg;
    logic                 cneg_e_reg;
    logic [INV_W-1:0]     inv_e_reg;

    assign adv       = !valid_reg[NSTAGE-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = valid_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg          <= '0;
            inv_band_width_reg <= INV_W'(ONE_Q);
        end
        else
        begin
            if (adv)
                valid_reg <= {valid_reg[NSTAGE-2:0], in_valid};
            if (cfg_wr_en)
                inv_band_width_reg <= cfg_wr_data;
        end
    end

    sshs_scale u_scale (
        .clk            (clk),
        .en             (adv),
        .level_value    (level_value),
        .inv_band_width (inv_band_width_reg),
        .umag           (umag_c),
        .neg            (neg_c),
        .inv            (inv_c)
    );

    // phase in quarter turns, [0,2]
    assign q      = {umag_c, 1'b0};
    assign cneg_c = q > (UMAG_W + 1)'(ONE_Q);
    always_comb
    begin
        if (!cneg_c)
        begin
            ts = q[UMAG_W-1:0];
            tc = ONE_Q - q[UMAG_W-1:0];
        end
        else
        begin
            ts = UMAG_W'(((UMAG_W + 1)'(ONE_Q) << 1) - q);
            tc = UMAG_W'(q - (UMAG_W + 1)'(ONE_Q));
        end
    end

    sshs_qsine u_sin (
        .clk  (clk),
        .en   (adv),
        .t    (ts),
        .sine (smag_e)
    );

    sshs_qsine u_cos (
        .clk  (clk),
        .en   (adv),
        .t    (tc),
        .sine (cmag_e)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            umag_d_reg <= umag_c;
            neg_d_reg  <= neg_c;
            cneg_d_reg <= cneg_c;
            inv_d_reg  <= inv_c;
            umag_e_reg <= umag_d_reg;
            neg_e_reg  <= neg_d_reg;
            cneg_e_reg <= cneg_d_reg;
            inv_e_reg  <= inv_d_reg;
        end
    end

    sshs_shape u_shape (
        .clk        (clk),
        .en         (adv),
        .smag       (smag_e),
        .cmag       (cmag_e),
        .cneg       (cneg_e_reg),
        .umag       (umag_e_reg),
        .neg        (neg_e_reg),
        .inv        (inv_e_reg),
        .step_value (step_value),
        .step_slope (step_slope)
    );

endmodule

// ===== rtl/sshs_scale.sv =====
// ----------------------------------------------------------------------------
// sshs_scale
// Three stages: magnitude of x, product with the reciprocal band width,
// rescale and clamp of |u| to one.
// ----------------------------------------------------------------------------
module sshs_scale (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [sshs_pkg::X_W-1:0]     level_value,
    input  logic        [sshs_pkg::INV_W-1:0]   inv_band_width,
    output logic        [sshs_pkg::UMAG_W-1:0]  umag,
    output logic                                neg,
    output logic        [sshs_pkg::INV_W-1:0]   inv
);
    import sshs_pkg::*;

    logic [X_W-1:0]    lvl_u;
    logic [X_W-1:0]    mag_next;
    logic [X_W-1:0]    mag_a_reg;
    logic              neg_a_reg;
    logic [INV_W-1:0]  inv_a_reg;
    logic [PROD_W-1:0] prod_b_reg;
    logic              neg_b_reg;
    logic [INV_W-1:0]  inv_b_reg;
    logic [UMAG_W-1:0] umag_next;
    logic [UMAG_W-1:0] umag_c_reg;
    logic              neg_c_reg;
    logic [INV_W-1:0]  inv_c_reg;

    assign lvl_u    = level_value;
    assign mag_next = lvl_u[X_W-1] ? (~lvl_u + 1'b1) : lvl_u;

    assign umag_next = (prod_b_reg[PROD_W-1:FRAC_BITS] > (PROD_W - FRAC_BITS)'(ONE_Q))
                     ? ONE_Q : prod_b_reg[FRAC_BITS +: UMAG_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_a_reg  <= mag_next;
            neg_a_reg  <= lvl_u[X_W-1];
            inv_a_reg  <= inv_band_width;
            prod_b_reg <= PROD_W'(mag_a_reg) * PROD_W'(inv_a_reg);
            neg_b_reg  <= neg_a_reg;
            inv_b_reg  <= inv_a_reg;
            umag_c_reg <= umag_next;
            neg_c_reg  <= neg_b_reg;
            inv_c_reg  <= inv_b_reg;
        end
    end

    assign umag = umag_c_reg;
    assign neg  = neg_c_reg;
    assign inv  = inv_c_reg;

endmodule

// ===== rtl/sshs_qsine.sv =====
// ----------------------------------------------------------------------------
// sshs_qsine
// Quarter-wave sine, sin(pi/2 * t) in Q30 for t in [0,1]: table read, then
// linear interpolation. Two stages.
// ----------------------------------------------------------------------------
module sshs_qsine (
    input  logic                                clk,
    input  logic                                en,
    input  logic [sshs_pkg::UMAG_W-1:0]         t,
    output logic [sshs_pkg::SINE_W-1:0]         sine
);
    import sshs_pkg::*;

    localparam int FSH = FRAC_BITS - SINE_IDX_W;

    logic                  sat;
    logic [SINE_IDX_W-1:0] idx;
    logic [SINE_IDX_W:0]   hi_idx;
    logic [SINE_W-1:0]     lo_w;
    logic [SINE_W-1:0]     hi_w;
    logic [FRAC_BITS-1:0]  frac_next;
    logic [SINE_W-1:0]     lo_reg;
    logic [SINE_W-1:0]     diff_reg;
    logic [FRAC_BITS-1:0]  frac_reg;
    logic [SINE_W+FRAC_BITS-1:0] interp;
    logic [SINE_W-1:0]     sine_reg;

    assign sat       = t[FRAC_BITS];
    assign idx       = t[FRAC_BITS-1:FSH];
    assign hi_idx    = {1'b0, idx} + 1'b1;
    assign lo_w      = sat ? SINE_ROM[SINE_DEPTH] : SINE_ROM[{1'b0, idx}];
    assign hi_w      = sat ? SINE_ROM[SINE_DEPTH] : SINE_ROM[hi_idx];
    assign frac_next = {t[FSH-1:0], {SINE_IDX_W{1'b0}}};

    assign interp = (SINE_W + FRAC_BITS)'(diff_reg) * (SINE_W + FRAC_BITS)'(frac_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg   <= lo_w;
            diff_reg <= (hi_w >= lo_w) ? (hi_w - lo_w) : '0;
            frac_reg <= frac_next;
            sine_reg <= lo_reg + interp[FRAC_BITS +: SINE_W];
        end
    end

    assign sine = sine_reg;

endmodule

// ===== rtl/sshs_shape.sv =====
// ----------------------------------------------------------------------------
// sshs_shape
// Three stages: sin/pi and half-raised cosine, then the step value and the
// slope product, then slope rounding and saturation into the output register.
// ----------------------------------------------------------------------------
module sshs_shape (
    input  logic                                clk,
    input  logic                                en,
    input  logic [sshs_pkg::SINE_W-1:0]         smag,
    input  logic [sshs_pkg::SINE_W-1:0]         cmag,
    input  logic                                cneg,
    input  logic [sshs_pkg::UMAG_W-1:0]         umag,
    input  logic                                neg,
    input  logic [sshs_pkg::INV_W-1:0]          inv,
    output logic [sshs_pkg::UMAG_W-1:0]         step_value,
    output logic [sshs_pkg::SLOPE_W-1:0]        step_slope
);
    import sshs_pkg::*;

    localparam int SPROD_W = SINE_W + INV_PI_W;
    localparam int HPROD_W = HVAL_W + INV_W;
    localparam int USH     = Q30 - FRAC_BITS;
    localparam int VSH     = Q30 + 1 - FRAC_BITS;
    localparam int VRAW_W  = TOT_W - VSH;

    logic [SPROD_W-1:0] sprod;
    logic [31:0]        h_sum;
    logic [SPI_W-1:0]   spi_f_reg;
    logic [HVAL_W-1:0]  hval_f_reg;
    logic [UMAG_W-1:0]  umag_f_reg;
    logic               neg_f_reg;
    logic [INV_W-1:0]   inv_f_reg;

    logic [TOT_W-1:0]   u30;
    logic [TOT_W-1:0]   mag_sum;
    logic [TOT_W-1:0]   total;
    logic [TOT_W-1:0]   rnd;
    logic [VRAW_W-1:0]  vraw;
    logic [UMAG_W-1:0]  value_next;
    logic [UMAG_W-1:0]  value_g_reg;
    logic [HPROD_W-1:0] hprod_g_reg;

    logic [63:0]        slope_sum;
    logic [63-Q30:0]    slope_raw;
    logic [UMAG_W-1:0]  step_value_reg;
    logic [SLOPE_W-1:0] step_slope_reg;

    assign sprod = SPROD_W'(smag) * SPROD_W'(INV_PI_Q30);
    assign h_sum = cneg ? (ONE_Q30 - 32'(cmag)) : (ONE_Q30 + 32'(cmag));

    assign u30     = TOT_W'(umag_f_reg) << USH;
    assign mag_sum = u30 + TOT_W'(spi_f_reg);
    always_comb
    begin
        if (!neg_f_reg)
            total = TOT_W'(ONE_Q30) + mag_sum;
        else if (TOT_W'(ONE_Q30) >= mag_sum)
            total = TOT_W'(ONE_Q30) - mag_sum;
        else
            total = '0;
    end
    assign rnd        = total + (TOT_W'(1) << USH);
    assign vraw       = rnd[TOT_W-1:VSH];
    assign value_next = (vraw > VRAW_W'(ONE_Q)) ? ONE_Q : vraw[UMAG_W-1:0];

    assign slope_sum = 64'(hprod_g_reg) + (64'(1) << (Q30 - 1));
    assign slope_raw = slope_sum[63:Q30];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spi_f_reg      <= sprod[Q30 +: SPI_W];
            hval_f_reg     <= h_sum[HVAL_W:1];
            umag_f_reg     <= umag;
            neg_f_reg      <= neg;
            inv_f_reg      <= inv;
            value_g_reg    <= value_next;
            hprod_g_reg    <= HPROD_W'(hval_f_reg) * HPROD_W'(inv_f_reg);
            step_value_reg <= value_g_reg;
            step_slope_reg <= (|slope_raw[63-Q30:SLOPE_W]) ? '1 : slope_raw[SLOPE_W-1:0];
        end
    end

    assign step_value = step_value_reg;
    assign step_slope = step_slope_reg;

endmodule
